// ===== src/lpht_pkg.sv =====
// Shared constants and types for the linear-probing key table.
// Used by the remainder unit and the top level; no dependencies.
package lpht_pkg;

  // Slot count of the key store.
  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  // Width of an effective slot count (1 .. DEPTH).
  localparam int unsigned NSZ_W  = ADDR_W + 1;

  localparam int unsigned KEY_W  = 31;
  localparam int unsigned SIZE_W = 11;
  localparam int unsigned KIND_W = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

  // The remainder unit retires this many key bits per cycle.
  localparam int unsigned MOD_DIGIT_W = 4;
  localparam int unsigned MOD_DIGITS  = (KEY_W + MOD_DIGIT_W - 1) / MOD_DIGIT_W;
  localparam int unsigned MOD_PAD_W   = MOD_DIGITS * MOD_DIGIT_W;
  localparam int unsigned MOD_CNT_W   = (MOD_DIGITS > 1) ? $clog2(MOD_DIGITS) : 1;

  // The last code is unused: such an item touches nothing and reports zeros.
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

endpackage

// ===== src/lpht_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module lpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== src/lpht_mod.sv =====
// Iterative remainder unit: key modulo slot count, a few key bits per cycle.
// Depends on lpht_pkg.
module lpht_mod (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [lpht_pkg::KEY_W-1:0] key_i,
  input  logic [lpht_pkg::NSZ_W-1:0] size_i,
  output logic                       done_o,
  output logic [lpht_pkg::ADDR_W-1:0] rem_o
);
  import lpht_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [MOD_CNT_W-1:0] cnt_q, cnt_d;
  logic [MOD_PAD_W-1:0] key_q, key_d;
  logic [NSZ_W-1:0]     n_q, n_d;
  logic [ADDR_W-1:0]    rem_q, rem_d;
  logic [ADDR_W-1:0]    step_rem;

  // Restoring remainder over one digit: shift in a bit, subtract the size if it fits.
  always_comb begin
    logic [ADDR_W-1:0] r;
    logic [NSZ_W-1:0]  sh;
    r = rem_q;
    for (int i = 0; i < MOD_DIGIT_W; i++) begin
      sh = {r, key_q[MOD_PAD_W-1-i]};
      if (sh >= n_q) begin
        sh = sh - n_q;
      end
      r = sh[ADDR_W-1:0];
    end
    step_rem = r;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    key_d  = key_q;
    n_d    = n_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      key_d  = MOD_PAD_W'(key_i);
      n_d    = size_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = step_rem;
      key_d = key_q << MOD_DIGIT_W;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == MOD_CNT_W'(MOD_DIGITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    n_q   <= n_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/linear_probe_hash_table.sv =====
// Linear-probing key table: top level with the probe sequencer and result register.
// Depends on lpht_pkg, lpht_mod and lpht_ram.
//
// Usage. Items arrive on the input channel (in_valid_i / in_ready_o) as a kind and a key:
// insert, delete or search. Every item returns exactly one result item on the output
// channel (out_valid_o / out_ready_i) with found (search hit) and dropped (insert found
// no empty slot). Kind 3 returns a result of zeros and touches nothing.
// The configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the slot
// count in use; it is always ready and should only be written while the block is idle.
// A slot count of zero acts as one, and one above the store depth acts as the depth.
//
// Sequence. The home slot comes from an iterative remainder unit that retires four key
// bits per cycle. The home slot read is issued in the cycle the remainder is ready, and
// the walk then reads each further slot in probe order. The next item is accepted only
// once the result of the last one has gone into the output register, so items are not
// overlapped inside the block. A kind 3 item skips the remainder unit and the store and
// goes straight to its result. The remainder and the walk set the pace.
//
// Reset. After reset a clearing pass writes zero to all 1024 slots, one per cycle,
// and no input item is accepted until the pass is over. When the receiver stalls,
// the finished result waits in the output register; the next input item may be
// accepted and worked on, and it waits for the register to free up before finishing.
module linear_probe_hash_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lpht_pkg::SIZE_W-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [lpht_pkg::KIND_W-1:0] kind_i,
  input  logic [lpht_pkg::KEY_W-1:0]  key_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic                        dropped_o
);
  import lpht_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_MOD   = 6'b000100,
    ST_HCHK  = 6'b001000,
    ST_PROBE = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [NSZ_W-1:0]  n_q, n_d;
  logic [ADDR_W-1:0] home_q, home_d;
  logic [ADDR_W-1:0] cur_q, cur_d;
  logic              res_found_q, res_found_d;
  logic              res_drop_q, res_drop_d;
  logic              out_valid_q, out_valid_d;
  logic              found_q, found_d;
  logic              dropped_q, dropped_d;

  logic              in_fire;
  logic [NSZ_W-1:0]  n_eff;
  logic              mod_start;
  logic              mod_done;
  logic [ADDR_W-1:0] mod_rem;
  logic [ADDR_W-1:0] base_addr;
  logic [NSZ_W-1:0]  base_inc;
  logic [ADDR_W-1:0] next_addr;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [KEY_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [KEY_W-1:0]  ram_rdata;
  logic [KEY_W-1:0]  want;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;

  // Effective slot count, clamped to the range 1 .. DEPTH.
  always_comb begin
    if (size_q == '0) begin
      n_eff = NSZ_W'(1);
    end else if (size_q > SIZE_W'(DEPTH)) begin
      n_eff = NSZ_W'(DEPTH);
    end else begin
      n_eff = NSZ_W'(size_q);
    end
  end

  assign mod_start = in_fire && (kind_i != KIND_NONE);

  lpht_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .key_i   (key_i),
    .size_i  (n_eff),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  // Next slot in probe order, wrapping within the slots in use.
  assign base_addr = (state_q == ST_PROBE) ? cur_q : home_q;
  assign base_inc  = NSZ_W'(base_addr) + 1'b1;
  assign next_addr = (base_inc == n_q) ? '0 : base_inc[ADDR_W-1:0];

  // Inserts look for an empty slot; deletes and searches look for the key.
  assign want = (kind_q == KIND_INSERT) ? '0 : key_q;

  always_comb begin
    case (state_q)
      ST_HCHK, ST_PROBE: ram_raddr = next_addr;
      default:           ram_raddr = mod_rem;
    endcase
  end

  lpht_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    size_d      = size_q;
    clr_d       = clr_q;
    kind_d      = kind_q;
    key_d       = key_q;
    n_d         = n_q;
    home_d      = home_q;
    cur_d       = cur_q;
    res_found_d = res_found_q;
    res_drop_d  = res_drop_q;
    out_valid_d = out_valid_q;
    found_d     = found_q;
    dropped_d   = dropped_q;
    ram_we      = 1'b0;
    ram_waddr   = home_q;
    ram_wdata   = '0;

    if (cfg_valid_i) begin
      size_d = cfg_data_i;
    end

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          kind_d      = kind_i;
          key_d       = key_i;
          n_d         = n_eff;
          res_found_d = 1'b0;
          res_drop_d  = 1'b0;
          state_d     = mod_start ? ST_MOD : ST_DONE;
        end
      end

      ST_MOD: begin
        // The home slot read is issued in the cycle the remainder is ready.
        if (mod_done) begin
          home_d  = mod_rem;
          state_d = ST_HCHK;
        end
      end

      ST_HCHK: begin
        cur_d = next_addr;
        if (ram_rdata == key_q) begin
          // Key already at home: insert is a no-op, delete clears it, search hits.
          if (kind_q == KIND_DELETE) begin
            ram_we    = 1'b1;
            ram_waddr = home_q;
          end
          res_found_d = (kind_q == KIND_SEARCH);
          state_d     = ST_DONE;
        end else if (ram_rdata == '0) begin
          // Empty home slot: insert takes it, delete and search miss.
          if (kind_q == KIND_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = home_q;
            ram_wdata = key_q;
          end
          state_d = ST_DONE;
        end else begin
          state_d = ST_PROBE;
        end
      end

      ST_PROBE: begin
        cur_d = next_addr;
        if (cur_q == home_q) begin
          // Walked all the way around without a match.
          res_drop_d = (kind_q == KIND_INSERT);
          state_d    = ST_DONE;
        end else if (ram_rdata == want) begin
          if (kind_q == KIND_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = cur_q;
            ram_wdata = key_q;
          end else if (kind_q == KIND_DELETE) begin
            ram_we    = 1'b1;
            ram_waddr = cur_q;
          end
          res_found_d = (kind_q == KIND_SEARCH);
          state_d     = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          found_d     = res_found_q;
          dropped_d   = res_drop_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      size_q      <= SIZE_RESET;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    key_q       <= key_d;
    n_q         <= n_d;
    home_q      <= home_d;
    cur_q       <= cur_d;
    res_found_q <= res_found_d;
    res_drop_q  <= res_drop_d;
    found_q     <= found_d;
    dropped_q   <= dropped_d;
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign dropped_o   = dropped_q;

endmodule
